>>> src/nnt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types and constants of the nearest-neighbor door tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;

    localparam int MAX_DOORS_DEF = 32;
    localparam int COORD_W       = 16;
    localparam int SUM_W         = 17;
    localparam int INDEX_W       = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int SQ_W          = 35;
    localparam int DIST_W        = 36;

    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y = 1'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] door_x1;
        logic signed [COORD_W-1:0] door_y1;
        logic signed [COORD_W-1:0] door_x2;
        logic signed [COORD_W-1:0] door_y2;
        logic                      last_door;
    } nnt_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] door_index;
        logic               last_visit;
    } nnt_out_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic                    vis;
    } nnt_door_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
        logic mark;
    } nnt_cell_ctrl_t;

endpackage : nnt_pkg
`default_nettype wire

>>> src/nnt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_cell
// One ring cell: holds a door center sum and its visited mark, loads and
// marks by its own index, and hands its contents to the neighbor on shift.
// ----------------------------------------------------------------------------
module nnt_cell
    import nnt_pkg::*;
#(
    parameter int CNT_W    = 6,
    parameter int CELL_IDX = 0
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire nnt_cell_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0] load_idx,
    input  wire logic [CNT_W-1:0] mark_idx,
    input  wire nnt_door_t      load_door,
    input  wire nnt_door_t      door_in,
    output nnt_door_t           door_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    logic                    vis_reg;
    logic                    vis_next;
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sx_next;
    logic signed [SUM_W-1:0] sy_reg;
    logic signed [SUM_W-1:0] sy_next;
    logic                    load_hit;
    logic                    mark_hit;

    assign load_hit = ctrl.load && (load_idx == MY_IDX);
    assign mark_hit = ctrl.mark && (mark_idx == MY_IDX);

    always_comb
    begin
        vis_next = vis_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        if (ctrl.shift)
        begin
            vis_next = door_in.vis;
            sx_next  = door_in.sx;
            sy_next  = door_in.sy;
        end
        else
        begin
            if (ctrl.clear || load_hit)
            begin
                vis_next = 1'b0;
            end
            else if (mark_hit)
            begin
                vis_next = 1'b1;
            end
            if (load_hit)
            begin
                sx_next = load_door.sx;
                sy_next = load_door.sy;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg <= 1'b0;
        end
        else
        begin
            vis_reg <= vis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        sy_reg <= sy_next;
    end

    assign door_out.sx  = sx_reg;
    assign door_out.sy  = sy_reg;
    assign door_out.vis = vis_reg;

endmodule : nnt_cell
`default_nettype wire

>>> src/nnt_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnt_dist
// Two-stage distance unit at the head of the ring: squares the offsets to the
// current position, then adds and keeps the nearest unvisited door.
// ----------------------------------------------------------------------------
module nnt_dist
    import nnt_pkg::*;
#(
    parameter int CNT_W = 6
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    head_valid,
    input  wire logic                    head_live,
    input  wire logic [CNT_W-1:0]        head_idx,
    input  wire nnt_door_t               head,
    input  wire logic signed [SUM_W-1:0] cur_x,
    input  wire logic signed [SUM_W-1:0] cur_y,
    output logic                         best_found,
    output logic [CNT_W-1:0]             best_idx,
    output logic signed [SUM_W-1:0]      best_sx,
    output logic signed [SUM_W-1:0]      best_sy
);

    logic signed [SUM_W:0]     dx;
    logic signed [SUM_W:0]     dy;
    logic signed [2*SUM_W+1:0] px;
    logic signed [2*SUM_W+1:0] py;

    logic                    s1_valid_reg;
    logic                    s1_ok_reg;
    logic [SQ_W-1:0]         s1_sqx_reg;
    logic [SQ_W-1:0]         s1_sqy_reg;
    logic [CNT_W-1:0]        s1_idx_reg;
    logic signed [SUM_W-1:0] s1_sx_reg;
    logic signed [SUM_W-1:0] s1_sy_reg;

    logic                    found_reg;
    logic [DIST_W-1:0]       best_d_reg;
    logic [CNT_W-1:0]        best_idx_reg;
    logic signed [SUM_W-1:0] best_sx_reg;
    logic signed [SUM_W-1:0] best_sy_reg;

    logic [DIST_W-1:0]       d_sum;
    logic                    take;

    assign dx = {head.sx[SUM_W-1], head.sx} - {cur_x[SUM_W-1], cur_x};
    assign dy = {head.sy[SUM_W-1], head.sy} - {cur_y[SUM_W-1], cur_y};
    assign px = dx * dx;
    assign py = dy * dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg  <= head_live && !head.vis;
        s1_sqx_reg <= px[SQ_W-1:0];
        s1_sqy_reg <= py[SQ_W-1:0];
        s1_idx_reg <= head_idx;
        s1_sx_reg  <= head.sx;
        s1_sy_reg  <= head.sy;
    end

    assign d_sum = {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
    assign take  = s1_valid_reg && s1_ok_reg && (!found_reg || (d_sum < best_d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_d_reg   <= d_sum;
            best_idx_reg <= s1_idx_reg;
            best_sx_reg  <= s1_sx_reg;
            best_sy_reg  <= s1_sy_reg;
        end
    end

    assign best_found = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_sx    = best_sx_reg;
    assign best_sy    = best_sy_reg;

endmodule : nnt_dist
`default_nettype wire

>>> src/nearest_neighbor_tour.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_tour
// Greedy nearest-neighbor tour over loaded door segments.
//
// Input channel (in_valid/in_ready/in_data): one door per transaction, taken while
// the block is loading. A door arriving with the store
// full is dropped. The transaction with last_door set starts the tour.
// Output channel (out_valid/out_ready/out_data): one transaction per door in
// visiting order; last_visit marks the final one.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): robot_x at index
// 0, robot_y at index 1, always ready; write only while idle.
// Each tour step rotates the ring of MAX_DOORS cells once past the distance
// unit, then passes through the drain and emit states before its result is
// registered. No input is taken during a tour.
// A stalled receiver holds the output register; the next step waits in its
// emit state until the register is free.
// Reset clears the door count, visited marks, robot position and outputs.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour
    import nnt_pkg::*;
#(
    parameter int MAX_DOORS = MAX_DOORS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire nnt_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output nnt_out_t                  out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_DOORS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DOORS);
    localparam logic [CNT_W-1:0] K_LAST   = CNT_W'(MAX_DOORS - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        door_cnt_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        step_reg;
    logic [CNT_W-1:0]        k_reg;
    logic signed [SUM_W-1:0] cur_x_reg;
    logic signed [SUM_W-1:0] cur_y_reg;
    logic [COORD_W-1:0]      robot_x_reg;
    logic [COORD_W-1:0]      robot_y_reg;
    logic                    out_valid_reg;
    nnt_out_t                out_data_reg;

    nnt_door_t               door_q [MAX_DOORS];
    nnt_door_t               load_door;
    nnt_cell_ctrl_t          cell_ctrl;

    logic                    in_fire;
    logic                    room;
    logic                    emit_fire;
    logic                    step_last;
    logic                    start;
    logic                    best_found;
    logic [CNT_W-1:0]        best_idx;
    logic signed [SUM_W-1:0] best_sx;
    logic signed [SUM_W-1:0] best_sy;
    logic [CNT_W+INDEX_W-1:0] idx_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign room      = (door_cnt_reg < CNT_MAX);
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign step_last = ((step_reg + CNT_ONE) == n_reg);
    assign start     = (in_fire && in_data.last_door) || (emit_fire && !step_last);
    assign cfg_ready = 1'b1;
    assign idx_ext   = {INDEX_W'(0), best_idx};

    assign load_door.sx  = SUM_W'(in_data.door_x1) + SUM_W'(in_data.door_x2);
    assign load_door.sy  = SUM_W'(in_data.door_y1) + SUM_W'(in_data.door_y2);
    assign load_door.vis = 1'b0;

    assign cell_ctrl.shift = (state_reg == ST_SCAN);
    assign cell_ctrl.clear = in_fire && in_data.last_door;
    assign cell_ctrl.load  = in_fire && room;
    assign cell_ctrl.mark  = emit_fire;

    for (genvar i = 0; i < MAX_DOORS; i++)
    begin : g_ring
        nnt_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .load_idx  (door_cnt_reg),
            .mark_idx  (best_idx),
            .load_door (load_door),
            .door_in   (door_q[(i + 1 == MAX_DOORS) ? 0 : i + 1]),
            .door_out  (door_q[i])
        );
    end

    nnt_dist #(
        .CNT_W (CNT_W)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .head_valid (state_reg == ST_SCAN),
        .head_live  (k_reg < n_reg),
        .head_idx   (k_reg),
        .head       (door_q[0]),
        .cur_x      (cur_x_reg),
        .cur_y      (cur_y_reg),
        .best_found (best_found),
        .best_idx   (best_idx),
        .best_sx    (best_sx),
        .best_sy    (best_sy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg <= '0;
            robot_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ROBOT_X)
            begin
                robot_x_reg <= cfg_data;
            end
            if (cfg_index == REG_ROBOT_Y)
            begin
                robot_y_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            door_cnt_reg  <= '0;
            n_reg         <= '0;
            step_reg      <= '0;
            k_reg         <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_data.last_door)
                        begin
                            n_reg     <= room ? (door_cnt_reg + CNT_ONE) : door_cnt_reg;
                            step_reg  <= '0;
                            k_reg     <= '0;
                            cur_x_reg <= {robot_x_reg, 1'b0};
                            cur_y_reg <= {robot_y_reg, 1'b0};
                            state_reg <= ST_SCAN;
                        end
                        if (room)
                        begin
                            door_cnt_reg <= door_cnt_reg + CNT_ONE;
                        end
                    end
                end
                ST_SCAN:
                begin
                    k_reg <= k_reg + CNT_ONE;
                    if (k_reg == K_LAST)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_data_reg.door_index <= idx_ext[INDEX_W-1:0];
                        out_data_reg.last_visit <= step_last;
                        cur_x_reg               <= best_sx;
                        cur_y_reg               <= best_sy;
                        step_reg                <= step_reg + CNT_ONE;
                        k_reg                   <= '0;
                        if (step_last)
                        begin
                            door_cnt_reg <= '0;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_emit_has_winner : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> best_found)
        else $error("emit without a nearest door");

    a_step_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (step_reg < n_reg))
        else $error("tour step beyond door count");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (door_cnt_reg <= CNT_MAX) && (n_reg <= CNT_MAX))
        else $error("door count beyond store size");

    a_scan_length : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (k_reg == K_LAST)) |=> (state_reg == ST_DRAIN))
        else $error("scan did not end after one ring rotation");
`endif

endmodule : nearest_neighbor_tour
`default_nettype wire
